// File: rtl/bdqs_pkg.sv
// Shared types and constants for the bounded deque with search.
// Holds opcodes, status codes and the controller/datapath handshake structs.
// No dependencies.
package bdqs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 4;
    localparam int OP_W          = 3;
    localparam int STAT_W        = 3;
    localparam int OCC_W         = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK    = 3'd0,
        OP_PUSH_FRONT   = 3'd1,
        OP_POP_BACK     = 3'd2,
        OP_POP_FRONT    = 3'd3,
        OP_READ         = 3'd4,
        OP_FIND         = 3'd5,
        OP_REMOVE_AT    = 3'd6,
        OP_REMOVE_VALUE = 3'd7
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_item;
        logic refuse;
        logic push;
        logic walk_init;
        logic rd_issue;
        logic take_hit;
        logic shift;
        logic shift_end;
        logic not_found;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic refuse;
        logic is_push;
        logic is_remove;
        logic hit;
        logic walk_idle;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/bdqs_ctrl.sv
// Sequencing state machine for the bounded deque with search.
// Depends on bdqs_pkg; drives the datapath through cmd_t and reads sts_t.
module bdqs_ctrl
    import bdqs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SEEK  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (sts.refuse)
                begin
                    cmd.refuse = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.is_push)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_SEEK;
                end
            end
            S_SEEK:
            begin
                cmd.rd_issue = 1'b1;
                priority if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = sts.is_remove ? S_SHIFT : S_DONE;
                end
                else if (sts.walk_idle)
                begin
                    cmd.not_found = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_SEEK;
                end
            end
            S_SHIFT:
            begin
                cmd.rd_issue = 1'b1;
                cmd.shift    = 1'b1;
                if (sts.walk_idle)
                begin
                    cmd.shift_end = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/bdqs_datapath.sv
// Datapath for the bounded deque with search: ring memory, pointers,
// read pipeline, result and output registers. Depends on bdqs_pkg.
module bdqs_datapath
    import bdqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] data_in,
    input  logic [POS_W-1:0]         position,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] data_out,
    output logic [POS_W-1:0]         found_position,
    output logic [STAT_W-1:0]        status,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam int OW = (CW > OCC_W) ? CW : OCC_W;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    logic [PW-1:0]            front_reg;
    logic [CW-1:0]            count_reg;
    opcode_t                  op_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic [POS_W-1:0]         pos_reg;

    logic [CW-1:0]            idx_reg;
    logic                     pend_reg;
    logic [PW-1:0]            pend_slot_reg;
    logic [CW-1:0]            pend_idx_reg;
    logic [PW-1:0]            hole_reg;

    logic signed [DATA_W-1:0] res_dout_reg;
    logic [POS_W-1:0]         res_fpos_reg;
    status_t                  res_status_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_dout_reg;
    logic [POS_W-1:0]         out_fpos_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [OCC_W-1:0]         out_occ_reg;

    logic [CW:0]   front_ext;
    logic [CW:0]   sum_idx, wrap_idx, sum_cnt, wrap_cnt;
    logic [PW-1:0] slot_idx, slot_cnt, front_dec, front_inc;
    logic          full, empty, pos_ge, more;
    logic          rd_fire, mem_we;
    logic [PW-1:0] waddr;
    logic signed [DATA_W-1:0] wdata;
    logic          chk_refuse;
    status_t       chk_code;
    logic [CW-1:0] start_idx;
    logic [IW-1:0] pos_ext, cnt_ext, pend_ext;
    logic [OW-1:0] occ_ext;
    logic          is_search;

    // Ring slot of a position: one conditional subtract, the sum stays below 2*DEPTH
    assign front_ext = {{(CW + 1 - PW){1'b0}}, front_reg};
    assign sum_idx   = {1'b0, idx_reg} + front_ext;
    assign wrap_idx  = sum_idx - (CW + 1)'(DEPTH);
    assign slot_idx  = (sum_idx >= (CW + 1)'(DEPTH)) ? wrap_idx[PW-1:0] : sum_idx[PW-1:0];
    assign sum_cnt   = {1'b0, count_reg} + front_ext;
    assign wrap_cnt  = sum_cnt - (CW + 1)'(DEPTH);
    assign slot_cnt  = (sum_cnt >= (CW + 1)'(DEPTH)) ? wrap_cnt[PW-1:0] : sum_cnt[PW-1:0];
    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = IW'(pos_reg);
    assign cnt_ext = IW'(count_reg);
    assign pos_ge  = (pos_ext >= cnt_ext);
    assign more    = (idx_reg < count_reg);
    assign rd_fire = cmd.rd_issue && more;

    assign is_search = (op_reg == OP_FIND) || (op_reg == OP_REMOVE_VALUE);

    always_comb
    begin
        chk_refuse = 1'b0;
        chk_code   = ST_OK;
        start_idx  = '0;
        unique case (op_reg)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    chk_refuse = 1'b1;
                    chk_code   = ST_FULL;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (empty)
                begin
                    chk_refuse = 1'b1;
                    chk_code   = ST_EMPTY;
                end
                if (op_reg == OP_POP_BACK)
                begin
                    start_idx = count_reg - 1'b1;
                end
            end
            OP_READ, OP_REMOVE_AT:
            begin
                priority if (empty)
                begin
                    chk_refuse = 1'b1;
                    chk_code   = ST_EMPTY;
                end
                else if (pos_ge)
                begin
                    chk_refuse = 1'b1;
                    chk_code   = ST_RANGE;
                end
                start_idx = pos_ext[CW-1:0];
            end
            default:
            begin
                start_idx = '0;
            end
        endcase
    end

    assign sts.refuse    = chk_refuse;
    assign sts.is_push   = (op_reg == OP_PUSH_BACK) || (op_reg == OP_PUSH_FRONT);
    assign sts.is_remove = (op_reg == OP_REMOVE_AT) || (op_reg == OP_REMOVE_VALUE);
    assign sts.hit       = pend_reg && (!is_search || (rdata_reg == data_reg));
    assign sts.walk_idle = !pend_reg && !more;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Memory write port: pushes, or the shift that closes a removal gap
    assign mem_we = cmd.push || (cmd.shift && pend_reg);
    always_comb
    begin
        waddr = hole_reg;
        wdata = rdata_reg;
        if (cmd.push)
        begin
            waddr = (op_reg == OP_PUSH_FRONT) ? front_dec : slot_cnt;
            wdata = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_fire)
        begin
            rdata_reg <= mem[slot_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_fire;
            if (cmd.push)
            begin
                count_reg <= count_reg + 1'b1;
                if (op_reg == OP_PUSH_FRONT)
                begin
                    front_reg <= front_dec;
                end
            end
            if (cmd.take_hit)
            begin
                if (op_reg == OP_POP_BACK)
                begin
                    count_reg <= count_reg - 1'b1;
                end
                if (op_reg == OP_POP_FRONT)
                begin
                    count_reg <= count_reg - 1'b1;
                    front_reg <= front_inc;
                end
            end
            if (cmd.shift_end)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pend_ext = IW'(pend_idx_reg);
    assign occ_ext  = OW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            op_reg   <= opcode_t'(opcode);
            data_reg <= data_in;
            pos_reg  <= position;
        end
        if (cmd.refuse)
        begin
            res_status_reg <= chk_code;
            res_dout_reg   <= '0;
            res_fpos_reg   <= '0;
        end
        if (cmd.push || cmd.walk_init)
        begin
            res_status_reg <= ST_OK;
            res_dout_reg   <= '0;
            res_fpos_reg   <= '0;
        end
        if (cmd.walk_init)
        begin
            idx_reg <= start_idx;
        end
        if (rd_fire)
        begin
            idx_reg       <= idx_reg + 1'b1;
            pend_slot_reg <= slot_idx;
            pend_idx_reg  <= idx_reg;
        end
        if (cmd.take_hit)
        begin
            if (op_reg == OP_FIND)
            begin
                res_fpos_reg <= pend_ext[POS_W-1:0];
            end
            else
            begin
                res_dout_reg <= rdata_reg;
            end
            hole_reg <= pend_slot_reg;
        end
        if (cmd.not_found)
        begin
            res_status_reg <= ST_NOT_FOUND;
        end
        if (cmd.shift && pend_reg)
        begin
            hole_reg <= pend_slot_reg;
        end
        if (cmd.out_load)
        begin
            out_dout_reg   <= res_dout_reg;
            out_fpos_reg   <= res_fpos_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= occ_ext[OCC_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_out       = out_dout_reg;
    assign found_position = out_fpos_reg;
    assign status         = out_status_reg;
    assign occupancy      = out_occ_reg;

endmodule

// File: rtl/bounded_deque_with_search.sv
// Top level of the bounded deque with search: stream ports, controller and datapath.
// Depends on bdqs_pkg, bdqs_ctrl and bdqs_datapath.
//
// A bounded double-ended queue of signed 32-bit words held in a single-port-read,
// single-port-write ring memory of DEPTH entries. Each input word carries an opcode
// in s_axis_tuser and gives exactly one result word with the occupancy after the
// operation. One item is worked on at a time; the result sits in an output register,
// so the next item is taken while a result still waits. Pushes and refused operations
// do not walk the ring; pops and reads read one entry; find walks the ring one entry per
// cycle from the front up to the match, or over every held entry when nothing matches;
// remove by value walks every held entry while shifting every entry after the match
// down one place per cycle; remove at a position walks from that position to the end.
// The memory read, registered before it is compared or moved, paces the walk.
// Entries are never cleared: only held entries are read.
module bounded_deque_with_search
    import bdqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_in [31:0], position [35:32], zero [39:36]
    input  logic [7:0]  s_axis_tuser,   // opcode [2:0], zero [7:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // data_out [31:0], found_position [35:32],
                                        // status [38:36], occupancy [43:39], zero [47:44]
);

    cmd_t cmd;
    sts_t sts;

    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         found_position;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;

    // Sequence each word: check, walk the ring, shift on removal, hand off the result
    bdqs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the ring, pointers and the output register
    bdqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .opcode         (s_axis_tuser[OP_W-1:0]),
        .data_in        (s_axis_tdata[DATA_W-1:0]),
        .position       (s_axis_tdata[DATA_W+POS_W-1:DATA_W]),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .data_out       (data_out),
        .found_position (found_position),
        .status         (status),
        .occupancy      (occupancy)
    );

    // Pack result fields from the lowest bit up, pad to whole bytes
    assign m_axis_tdata = {4'b0000, occupancy, status, found_position, data_out};

endmodule

// File: sim/tb_bounded_deque_with_search.sv
// Self-checking testbench for the bounded deque with search: a directed table, then random
// words under four pacing phases, every reply checked against an in-bench deque model.
// Depends on bdqs_pkg and bounded_deque_with_search.
module tb_bounded_deque_with_search;
    import bdqs_pkg::*;

    localparam int RING_DEPTH      = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WORDS_PER_PHASE = 400;
    localparam int NUM_PHASES      = 4;
    localparam int NUM_ROWS        = 25;
    // Percent of cycles the sender idles / the receiver stalls, per phase
    localparam int SEND_IDLE  [NUM_PHASES] = '{0, 75, 0, 31};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 75, 31};

    typedef struct packed {
        opcode_t     op;
        logic [31:0] data;
        logic [3:0]  pos;
    } deque_cmd_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [3:0]  found_pos;
        status_t     status;
        logic [4:0]  occupancy;
    } deque_resp_t;

    // One row of the directed table: the command, how many times to repeat it (data
    // advances by one per repeat), and a typed-in reply where one is given.
    typedef struct packed {
        deque_cmd_t  cmd;
        logic [4:0]  reps;
        logic        has_lit;
        deque_resp_t lit;
    } stim_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [39:0] s_axis_tdata  = '0;
    logic [7:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    logic        in_fire;
    logic        out_fire;

    // Deque model state
    logic [31:0] model_ring [RING_DEPTH];
    int          model_head  = 0;
    int          model_count = 0;

    deque_resp_t owed_replies [$];
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          mismatches      = 0;
    int          words_sent      = 0;
    int          replies_checked = 0;
    int          peak_fill       = 0;
    int          status_seen [5] = '{0, 0, 0, 0, 0};

    stim_row_t directed_rows [NUM_ROWS] = '{
        // Everything refused on an empty deque
        '{'{OP_POP_BACK,     32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_EMPTY, 5'd0}},
        '{'{OP_POP_FRONT,    32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_EMPTY, 5'd0}},
        '{'{OP_READ,         32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_EMPTY, 5'd0}},
        '{'{OP_REMOVE_AT,    32'h0000_0000, 4'd15}, 5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_EMPTY, 5'd0}},
        '{'{OP_FIND,         32'hffff_ffff, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_NOT_FOUND, 5'd0}},
        '{'{OP_REMOVE_VALUE, 32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_NOT_FOUND, 5'd0}},
        // Extremes at both ends
        '{'{OP_PUSH_BACK,    32'h7fff_ffff, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_OK, 5'd1}},
        '{'{OP_PUSH_FRONT,   32'h8000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_OK, 5'd2}},
        '{'{OP_READ,         32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h8000_0000, 4'd0, ST_OK, 5'd2}},
        '{'{OP_READ,         32'h0000_0000, 4'd15}, 5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_RANGE, 5'd2}},
        '{'{OP_REMOVE_AT,    32'h0000_0000, 4'd2},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_RANGE, 5'd2}},
        '{'{OP_FIND,         32'h7fff_ffff, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd1, ST_OK, 5'd2}},
        // Pop back down to one element, then the last one
        '{'{OP_POP_BACK,     32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h7fff_ffff, 4'd0, ST_OK, 5'd1}},
        '{'{OP_POP_BACK,     32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h8000_0000, 4'd0, ST_OK, 5'd0}},
        // Fill across the ring wrap: values -1 up to 14
        '{'{OP_PUSH_BACK,    32'hffff_ffff, 4'd0},  5'd16, 1'b0, '0},
        '{'{OP_PUSH_FRONT,   32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_FULL, 5'd16}},
        '{'{OP_PUSH_BACK,    32'h7fff_ffff, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_FULL, 5'd16}},
        '{'{OP_READ,         32'h0000_0000, 4'd15}, 5'd1, 1'b0, '0},
        '{'{OP_FIND,         32'h0000_000e, 4'd0},  5'd1, 1'b0, '0},
        // Remove at the back end, the front end, then by value in the middle
        '{'{OP_REMOVE_AT,    32'h0000_0000, 4'd15}, 5'd1, 1'b0, '0},
        '{'{OP_REMOVE_AT,    32'h0000_0000, 4'd0},  5'd1, 1'b0, '0},
        '{'{OP_REMOVE_VALUE, 32'h0000_0005, 4'd0},  5'd1, 1'b0, '0},
        '{'{OP_REMOVE_VALUE, 32'h8000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_NOT_FOUND, 5'd13}},
        '{'{OP_POP_FRONT,    32'h0000_0000, 4'd0},  5'd13, 1'b0, '0},
        '{'{OP_READ,         32'h0000_0000, 4'd0},  5'd1, 1'b1,
          '{32'h0000_0000, 4'd0, ST_EMPTY, 5'd0}}
    };

    bounded_deque_with_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ring slot of a position counted from the front
    function automatic int slot_at(int pos);
        return (model_head + pos) % RING_DEPTH;
    endfunction

    // First position holding value, or the count when nothing matches
    function automatic int find_first(logic [31:0] value);
        for (int p = 0; p < model_count; p++)
        begin
            if (model_ring[slot_at(p)] == value)
                return p;
        end
        return model_count;
    endfunction

    // Drop the element at pos and close the gap toward the front
    function automatic logic [31:0] take_out(int pos);
        logic [31:0] value;
        value = model_ring[slot_at(pos)];
        for (int p = pos; p + 1 < model_count; p++)
            model_ring[slot_at(p)] = model_ring[slot_at(p + 1)];
        model_count--;
        return value;
    endfunction

    // Apply one command to the deque model and return the reply it owes
    function automatic deque_resp_t deque_apply(deque_cmd_t cmd);
        deque_resp_t resp;
        int          hit;
        resp = '{32'h0, 4'd0, ST_OK, 5'd0};
        case (cmd.op)
            OP_PUSH_BACK:
            begin
                if (model_count >= RING_DEPTH)
                    resp.status = ST_FULL;
                else
                begin
                    model_ring[slot_at(model_count)] = cmd.data;
                    model_count++;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (model_count >= RING_DEPTH)
                    resp.status = ST_FULL;
                else
                begin
                    model_head = (model_head + RING_DEPTH - 1) % RING_DEPTH;
                    model_ring[model_head] = cmd.data;
                    model_count++;
                end
            end
            OP_POP_BACK:
            begin
                if (model_count == 0)
                    resp.status = ST_EMPTY;
                else
                begin
                    resp.data_out = model_ring[slot_at(model_count - 1)];
                    model_count--;
                end
            end
            OP_POP_FRONT:
            begin
                if (model_count == 0)
                    resp.status = ST_EMPTY;
                else
                begin
                    resp.data_out = model_ring[model_head];
                    model_head = (model_head + 1) % RING_DEPTH;
                    model_count--;
                end
            end
            OP_READ, OP_REMOVE_AT:
            begin
                if (model_count == 0)
                    resp.status = ST_EMPTY;
                else if (int'(cmd.pos) >= model_count)
                    resp.status = ST_RANGE;
                else if (cmd.op == OP_READ)
                    resp.data_out = model_ring[slot_at(cmd.pos)];
                else
                    resp.data_out = take_out(cmd.pos);
            end
            default: // find or remove by value
            begin
                hit = find_first(cmd.data);
                if (hit >= model_count)
                    resp.status = ST_NOT_FOUND;
                else if (cmd.op == OP_FIND)
                    resp.found_pos = 4'(hit);
                else
                    resp.data_out = take_out(hit);
            end
        endcase
        resp.occupancy = 5'(model_count);
        return resp;
    endfunction

    // Build one random command. fill_bias is the percent of pushes, so alternating it
    // swings the deque between full and empty. Searches mostly target held values and
    // positions mostly land inside the count, to reach the walk and the shift.
    function automatic deque_cmd_t random_word(int fill_bias);
        deque_cmd_t cmd;
        int         pick;
        cmd.data = $urandom();
        cmd.pos  = 4'($urandom_range(15));
        if ($urandom_range(99) < fill_bias)
            cmd.op = ($urandom_range(1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
            cmd.op = opcode_t'($urandom_range(7, 2));
        pick = $urandom_range(9);
        case (cmd.op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                // Small pool gives duplicates, so first-match order matters
                if (pick < 4)
                    cmd.data = 32'($urandom_range(7)) - 32'd3;
                else if (pick < 6)
                begin
                    case ($urandom_range(3))
                        0:       cmd.data = 32'h7fff_ffff;
                        1:       cmd.data = 32'h8000_0000;
                        2:       cmd.data = 32'h0000_0000;
                        default: cmd.data = 32'hffff_ffff;
                    endcase
                end
            end
            OP_FIND, OP_REMOVE_VALUE:
            begin
                if (model_count > 0 && pick < 5)
                    cmd.data = model_ring[slot_at($urandom_range(model_count - 1))];
                else if (pick < 7)
                    cmd.data = 32'($urandom_range(7)) - 32'd3;
            end
            default:
            begin
                if (model_count > 0 && pick < 8)
                    cmd.pos = 4'($urandom_range(model_count - 1));
            end
        endcase
        return cmd;
    endfunction

    // Present one word after a random gap, hold it until taken, then log the reply it owes.
    // A typed-in reply replaces the predicted one, but the model still advances.
    task automatic send_word(input deque_cmd_t cmd, input logic use_lit,
                             input deque_resp_t lit);
        deque_resp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cmd.pos, cmd.data};
        s_axis_tuser  <= {5'b0, cmd.op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = deque_apply(cmd);
        owed_replies.push_back(use_lit ? lit : predicted);
        words_sent++;
        if (model_count > peak_fill)
            peak_fill = model_count;
    endtask

    // Drop valid and hold off until every owed reply has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
    endtask

    // Reply side: check each taken word against the oldest owed reply, then draw the
    // next ready from the stall rate of the current phase.
    always @(posedge clk)
    begin : reply_check
        deque_resp_t want;
        if (rst_n && out_fire)
        begin
            if (owed_replies.size() == 0)
            begin
                $error("reply word with none owed: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = owed_replies.pop_front();
                replies_checked++;
                if (int'(want.status) < 5)
                    status_seen[want.status]++;
                if (m_axis_tdata[31:0] !== want.data_out)
                begin
                    $error("data_out: expected %h, got %h", want.data_out, m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (m_axis_tdata[35:32] !== want.found_pos)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_pos, m_axis_tdata[35:32]);
                    mismatches++;
                end
                if (m_axis_tdata[38:36] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[38:36]);
                    mismatches++;
                end
                if (m_axis_tdata[43:39] !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, m_axis_tdata[43:39]);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if no word moves on either side for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (in_fire || out_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        deque_cmd_t cmd;
        int         fill_bias;
        foreach (model_ring[i])
            model_ring[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling on either side
        foreach (directed_rows[r])
        begin
            for (int i = 0; i < int'(directed_rows[r].reps); i++)
            begin
                cmd      = directed_rows[r].cmd;
                cmd.data = cmd.data + 32'(i);
                send_word(cmd, directed_rows[r].has_lit, directed_rows[r].lit);
            end
        end
        hold_until_drained();

        // Random words under each pacing phase; drain fully between phases
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                fill_bias = ((n / 48) % 2 == 0) ? 60 : 20;
                cmd = random_word(fill_bias);
                send_word(cmd, 1'b0, '0);
            end
            hold_until_drained();
        end

        // Let any stray reply surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (owed_replies.size() != 0)
        begin
            $error("%0d replies never arrived", owed_replies.size());
            mismatches += owed_replies.size();
        end

        $display("Sent %0d words over %0d pacing phases, checked %0d replies, peak fill %0d.",
                 words_sent, NUM_PHASES, replies_checked, peak_fill);
        $display("Replies by status: ok %0d, empty %0d, full %0d, range %0d, not found %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/bdqs_pkg.sv
rtl/bdqs_ctrl.sv
rtl/bdqs_datapath.sv
rtl/bounded_deque_with_search.sv
sim/tb_bounded_deque_with_search.sv
